// ===== rtl/vtyp_pkg.sv =====
// Shared types, constants and the whole-degree sine and cosine tables for the
// vector to yaw/pitch unit. Has no dependencies of its own.
package vtyp_pkg;

	localparam int TAB_LEN  = 45;
	localparam int TAB_LAST = TAB_LEN - 1;
	localparam int KW       = 6;
	localparam int DEG_W    = 9;
	localparam int FL_W     = 7;
	localparam int OUT_W    = 24;

	localparam logic [DEG_W-1:0] DEG_45  = 9'd45;
	localparam logic [DEG_W-1:0] DEG_89  = 9'd89;
	localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
	localparam logic [DEG_W-1:0] DEG_179 = 9'd179;
	localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
	localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
	localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

	localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
	localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

	typedef logic [63:0] tab_t [0:TAB_LEN-1];

	typedef enum logic [1:0] {
		TAB_COS  = 2'd0,
		TAB_SIN  = 2'd1,
		TAB_COS2 = 2'd2,
		TAB_SIN2 = 2'd3
	} tab_sel_t;

	// how one quadrant angle is resolved
	typedef enum logic [1:0] {
		QA_ZERO   = 2'd0,
		QA_RIGHT  = 2'd1,
		QA_HALF   = 2'd2,
		QA_SEARCH = 2'd3
	} qa_code_t;

	typedef struct packed {
		logic xn;
		logic yn;
		logic zn;
		logic vert;
		logic az_nz;
	} flags_t;

	typedef struct packed {
		flags_t   f;
		qa_code_t yc;
		qa_code_t pc;
		logic     yflip;
		logic     pflip;
	} side_t;

	// Q62 product of two Q62 values
	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// build a table of whole degrees 0..44 by repeated one-degree rotation
	function automatic tab_t vtyp_tab(input tab_sel_t sel);
		logic [63:0] c [0:TAB_LEN-1];
		logic [63:0] s [0:TAB_LEN-1];
		logic [63:0] x, x2, t, s1, c1;
		tab_t        r;
		x  = (PI_Q60 * 64'd4) / 64'd180;
		x2 = mulq(x, x);
		t  = x;
		s1 = x;
		t  = mulq(t, x2) / 64'd6;  s1 = s1 - t;
		t  = mulq(t, x2) / 64'd20; s1 = s1 + t;
		t  = mulq(t, x2) / 64'd42; s1 = s1 - t;
		t  = mulq(t, x2) / 64'd72; s1 = s1 + t;
		t  = x2 / 64'd2;           c1 = Q62_ONE - t;
		t  = mulq(t, x2) / 64'd12; c1 = c1 + t;
		t  = mulq(t, x2) / 64'd30; c1 = c1 - t;
		t  = mulq(t, x2) / 64'd56; c1 = c1 + t;
		c[0] = Q62_ONE;
		s[0] = 64'd0;
		for (int k = 1; k < TAB_LEN; k++) begin
			c[k] = mulq(c[k-1], c1) - mulq(s[k-1], s1);
			s[k] = mulq(s[k-1], c1) + mulq(c[k-1], s1);
		end
		for (int k = 0; k < TAB_LEN; k++) begin
			unique case (sel)
				TAB_COS:  r[k] = c[k];
				TAB_SIN:  r[k] = s[k];
				TAB_COS2: r[k] = mulq(c[k], c[k]);
				TAB_SIN2: r[k] = mulq(s[k], s[k]);
				default:  r[k] = c[k];
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/vtyp_search.sv =====
// Pipelined binary search for floor(atan(n/d)), or of sqrt(n/d) when SQUARED,
// in whole degrees, 0 < n < d. Depends on vtyp_pkg for the angle tables.
module vtyp_search #(
	parameter int NW      = 16,
	parameter bit SQUARED = 1'b0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [NW-1:0]           n,
	input  logic [NW-1:0]           d,
	output logic [vtyp_pkg::KW-1:0] k
);
	import vtyp_pkg::*;

	localparam int   STEPS = KW;
	localparam int   PW    = NW + 32;
	localparam int   LW    = NW + 64;
	localparam tab_t WC    = vtyp_tab(SQUARED ? TAB_COS2 : TAB_COS);
	localparam tab_t WS    = vtyp_tab(SQUARED ? TAB_SIN2 : TAB_SIN);

	logic [NW-1:0] n_st [0:STEPS];
	logic [NW-1:0] d_st [0:STEPS];
	logic [KW-1:0] k_st [0:STEPS];

	assign n_st[0] = n;
	assign d_st[0] = d;
	assign k_st[0] = '0;
	assign k       = k_st[STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [KW-1:0] STEP_BIT = KW'(1) << (STEPS - 1 - j);

		logic [KW-1:0] cand, idx;
		logic          cv;
		logic [NW-1:0] n_sa, d_sa;
		logic [KW-1:0] k_sa, cand_sa;
		logic          cv_sa;
		logic [PW-1:0] pcl_sa, pch_sa, psl_sa, psh_sa;
		logic [LW-1:0] lhs, rhs;

		assign cand = k_st[j] | STEP_BIT;
		assign cv   = (cand <= KW'(TAB_LAST));
		assign idx  = cv ? cand : '0;

		// first half: partial products against the tables at the probe angle
		always_ff @(posedge clk) begin
			if (en) begin
				n_sa    <= n_st[j];
				d_sa    <= d_st[j];
				k_sa    <= k_st[j];
				cand_sa <= cand;
				cv_sa   <= cv;
				pcl_sa  <= PW'(n_st[j]) * PW'(WC[idx][31:0]);
				pch_sa  <= PW'(n_st[j]) * PW'(WC[idx][63:32]);
				psl_sa  <= PW'(d_st[j]) * PW'(WS[idx][31:0]);
				psh_sa  <= PW'(d_st[j]) * PW'(WS[idx][63:32]);
			end
		end

		assign lhs = {pch_sa, 32'd0} + LW'(pcl_sa);
		assign rhs = {psh_sa, 32'd0} + LW'(psl_sa);

		// second half: keep an in-range probe if n*cos >= d*sin (squares if SQUARED)
		always_ff @(posedge clk) begin
			if (en) begin
				n_st[j+1] <= n_sa;
				d_st[j+1] <= d_sa;
				k_st[j+1] <= (cv_sa && (lhs >= rhs)) ? cand_sa : k_sa;
			end
		end
	end

endmodule

// ===== rtl/vector_to_yaw_pitch_degrees_unit.sv =====
// Top level of the vector to yaw/pitch unit: stream ports, squaring,
// quadrant folding and the final degree mapping. Uses vtyp_pkg, vtyp_search.
//
// Usage:
//  - Slave stream carries one direction vector per request: x, y and z as
//    two's complement words. Master stream returns pitch and yaw in whole
//    degrees 0..359, truncated toward zero, negatives wrapped by adding 360.
//  - Each angle is found exactly: the ratio of the two legs is compared
//    against a table of whole-degree sines and cosines by a six-step binary
//    search, every step a pair of register stages (partial products, then
//    add and compare). Multiples of 45 degrees and axis cases bypass it.
//  - The path is 17 register stages: 4 front stages (magnitude, square, sum,
//    classify), 12 search stages, 1 output register.
//  - Throughput is one request per cycle, back to back, unless the receiver stalls.
//  - When the receiver stalls with a result held, the whole pipeline holds
//    and s_axis_tready drops; nothing is dropped or repeated. Bubbles move up
//    freely while the output register is empty.
//  - Reset clears all valid bits; the unit then accepts at once.
module vector_to_yaw_pitch_degrees_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// fields from bit 0 up: x_component, y_component, z_component, zero pad
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// fields from bit 0 up: pitch_deg, yaw_deg, zero pad
	output logic [vtyp_pkg::OUT_W-1:0]            m_axis_tdata
);
	import vtyp_pkg::*;

	localparam int C        = COORD_BITS;
	localparam int SQW      = 2 * C;
	localparam int QW       = 2 * C + 1;
	localparam int SRCH_LAT = 2 * KW;

	logic en;

	// --- stage 1: split into sign and magnitude --------------------------
	logic [C-1:0] xv, yv, zv;
	logic         v_s1;
	logic [C-1:0] xm_s1, ym_s1, zm_s1;
	flags_t       f_s1;

	assign xv = s_axis_tdata[C-1:0];
	assign yv = s_axis_tdata[2*C-1:C];
	assign zv = s_axis_tdata[3*C-1:2*C];

	// --- stage 2: squares -------------------------------------------------
	logic           v_s2;
	logic [C-1:0]   xm_s2, ym_s2;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2;
	flags_t         f_s2;

	// --- stage 3: horizontal length squared --------------------------------
	logic           v_s3;
	logic [C-1:0]   xm_s3, ym_s3;
	logic [QW-1:0]  r2_s3;
	logic [SQW-1:0] z2_s3;
	flags_t         f_s3;

	// --- stage 4: classify and fold each angle into the first octant -------
	logic           v_s4;
	logic [C-1:0]   yn_s4, yd_s4;
	logic [QW-1:0]  pn_s4, pd_s4;
	side_t          side_s4;

	logic [QW-1:0]  z2w;

	// --- search and alignment ---------------------------------------------
	logic [KW-1:0]  k_yaw, k_pit;
	side_t          side_d [0:SRCH_LAT-1];
	logic           vld_d  [0:SRCH_LAT-1];

	// --- output -------------------------------------------------------------
	logic           out_v_q;
	logic [OUT_W-1:0] out_q;
	side_t          sd;
	logic [FL_W-1:0] fl_y, fl_p;
	logic [DEG_W-1:0] m_y, yaw, pitch;

	function automatic qa_code_t classify(input logic p_zero, input logic q_zero,
	                                      input logic eq);
		qa_code_t c;
		priority if (p_zero) c = QA_ZERO;
		else if (q_zero)     c = QA_RIGHT;
		else if (eq)         c = QA_HALF;
		else                 c = QA_SEARCH;
		return c;
	endfunction

	function automatic logic [FL_W-1:0] fold(input qa_code_t c, input logic flip,
	                                         input logic [KW-1:0] kk);
		logic [FL_W-1:0] r;
		unique case (c)
			QA_ZERO:   r = '0;
			QA_RIGHT:  r = FL_W'(DEG_90);
			QA_HALF:   r = FL_W'(DEG_45);
			QA_SEARCH: r = flip ? (FL_W'(DEG_89) - FL_W'(kk)) : FL_W'(kk);
			default:   r = '0;
		endcase
		return r;
	endfunction

	// the whole pipeline advances unless a result is held by the receiver
	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// the most negative value keeps its true magnitude in C bits
			xm_s1   <= xv[C-1] ? (~xv + C'(1)) : xv;
			ym_s1   <= yv[C-1] ? (~yv + C'(1)) : yv;
			zm_s1   <= zv[C-1] ? (~zv + C'(1)) : zv;
			f_s1    <= '{xn: xv[C-1], yn: yv[C-1], zn: zv[C-1], vert: 1'b0, az_nz: 1'b0};

			xm_s2   <= xm_s1;
			ym_s2   <= ym_s1;
			sx_s2   <= SQW'(xm_s1) * SQW'(xm_s1);
			sy_s2   <= SQW'(ym_s1) * SQW'(ym_s1);
			sz_s2   <= SQW'(zm_s1) * SQW'(zm_s1);
			f_s2    <= '{xn: f_s1.xn, yn: f_s1.yn, zn: f_s1.zn,
			             vert: (xm_s1 == '0) && (ym_s1 == '0), az_nz: (zm_s1 != '0)};

			xm_s3   <= xm_s2;
			ym_s3   <= ym_s2;
			r2_s3   <= QW'(sx_s2) + QW'(sy_s2);
			z2_s3   <= sz_s2;
			f_s3    <= f_s2;

			// yaw: atan2(|y|,|x|); pitch: atan2(|z|, r), searched as z^2 vs x^2 + y^2
			yn_s4   <= (ym_s3 > xm_s3) ? xm_s3 : ym_s3;
			yd_s4   <= (ym_s3 > xm_s3) ? ym_s3 : xm_s3;
			pn_s4   <= (z2w > r2_s3) ? r2_s3 : z2w;
			pd_s4   <= (z2w > r2_s3) ? z2w : r2_s3;
			side_s4 <= '{f: f_s3,
			             yc: classify(ym_s3 == '0, xm_s3 == '0, ym_s3 == xm_s3),
			             pc: classify(z2w == '0, r2_s3 == '0, z2w == r2_s3),
			             yflip: (ym_s3 > xm_s3),
			             pflip: (z2w > r2_s3)};
		end
	end

	assign z2w = QW'(z2_s3);

	vtyp_search #(.NW(C), .SQUARED(1'b0)) u_yaw_search (
		.clk (clk),
		.en  (en),
		.n   (yn_s4),
		.d   (yd_s4),
		.k   (k_yaw)
	);

	vtyp_search #(.NW(QW), .SQUARED(1'b1)) u_pitch_search (
		.clk (clk),
		.en  (en),
		.n   (pn_s4),
		.d   (pd_s4),
		.k   (k_pit)
	);

	// carry the side information alongside the search stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SRCH_LAT; i++) vld_d[i] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= v_s4;
			for (int i = 1; i < SRCH_LAT; i++) vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s4;
			for (int i = 1; i < SRCH_LAT; i++) side_d[i] <= side_d[i-1];
		end
	end

	// map the octant angle back to the full circle
	always_comb begin
		sd   = side_d[SRCH_LAT-1];
		fl_y = fold(sd.yc, sd.yflip, k_yaw);
		fl_p = fold(sd.pc, sd.pflip, k_pit);
		if (sd.f.xn)
			m_y = (sd.yc != QA_SEARCH) ? (DEG_180 - DEG_W'(fl_y)) : (DEG_179 - DEG_W'(fl_y));
		else
			m_y = DEG_W'(fl_y);
		if (sd.f.vert) begin
			yaw   = '0;
			pitch = (!sd.f.zn && sd.f.az_nz) ? DEG_90 : DEG_270;
		end else begin
			yaw   = (sd.f.yn && (m_y != '0)) ? (DEG_360 - m_y) : m_y;
			pitch = (sd.f.zn && (fl_p != '0)) ? (DEG_360 - DEG_W'(fl_p)) : DEG_W'(fl_p);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vld_d[SRCH_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {(OUT_W - 2*DEG_W)'(0), yaw, pitch};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule
